/* hdl/twpr_pkg.sv */
// ----------------------------------------------------------------------------
// twpr_pkg
// Shared types and constants of the tic window packet receiver: verdict
// codes, field widths and the stream packing layout.
// ----------------------------------------------------------------------------
package twpr_pkg;

  localparam int unsigned NodeFieldW  = 2;
  localparam int unsigned PlayerW     = 7;
  localparam int unsigned LowW        = 8;
  localparam int unsigned LocalTicW   = 31;
  localparam int unsigned TicW        = 32;
  localparam int unsigned HoldoffW    = 8;

  localparam int unsigned InDataW     = 64;
  localparam int unsigned InUserW     = 4;
  localparam int unsigned OutDataW    = 128;
  localparam int unsigned OutUserW    = 3;

  localparam logic [HoldoffW-1:0] HoldoffReset = 8'd10;
  localparam int signed           WindowHalf   = 64;

  typedef enum logic [2:0] {
    VERDICT_SETUP    = 3'd0,
    VERDICT_EXIT     = 3'd1,
    VERDICT_EXIT_IGN = 3'd2,
    VERDICT_KILL     = 3'd3,
    VERDICT_DUP      = 3'd4,
    VERDICT_OOO      = 3'd5,
    VERDICT_MISSED   = 3'd6,
    VERDICT_ACCEPT   = 3'd7
  } verdict_e;

  typedef struct packed {
    logic [LocalTicW-1:0]  local_tic;
    logic [LowW-1:0]       retransmit_low;
    logic [LowW-1:0]       tic_count;
    logic [LowW-1:0]       start_low;
    logic [PlayerW-1:0]    player_id;
    logic [NodeFieldW-1:0] source_node;
  } in_data_t;

  typedef struct packed {
    logic flag_retransmit;
    logic flag_kill;
    logic flag_exit;
    logic flag_setup;
  } in_user_t;

  typedef struct packed {
    logic [OutDataW-121-1:0] pad;
    logic [TicW-1:0]         resend_from;
    logic                    resend_armed;
    logic                    need_resend_now;
    logic [TicW-1:0]         node_tic_now;
    logic [TicW-1:0]         first_dest_tic;
    logic [LowW-1:0]         copy_count;
    logic [LowW-1:0]         copy_offset;
    logic [PlayerW-1:0]      player_out;
  } out_data_t;

  function automatic logic [TicW-1:0] expand_low(input logic [LowW-1:0]      low,
                                                 input logic [LocalTicW-1:0] mt);
    logic signed [LowW+1:0] delta;
    logic [TicW-1:0]        base;
    logic [TicW-1:0]        adj;
    delta = $signed({2'b00, low}) - $signed({2'b00, mt[LowW-1:0]});
    base  = {1'b0, mt[LocalTicW-1:LowW], {LowW{1'b0}}};
    if (delta > (LowW+2)'(WindowHalf)) begin
      adj = 32'hFFFF_FF00;
    end else if (delta < -(LowW+2)'(WindowHalf)) begin
      adj = 32'h0000_0100;
    end else begin
      adj = '0;
    end
    return base + {{(TicW-LowW){1'b0}}, low} + adj;
  endfunction

endpackage

/* hdl/tic_window_packet_receiver_core.sv */
// ----------------------------------------------------------------------------
// tic_window_packet_receiver_core
// Judges received packet headers against per-node receive state and
// reports the verdict, payload slice and resend status of each packet.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                    | payload
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | packet header, flags in tuser
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | result, verdict in tuser
//  cfg       | in        | cfg_we_i                     | resend holdoff
//
//  One packet per cycle unless m_axis stalls; a header passes the input register
//  and then the output register. The input register and the per-node state
//  read-modify-write set the rate. A stalled result holds in the output register;
//  the input register still refills when the result is taken in the same cycle.
//  Reset clears all node state, marks every node present, holdoff becomes 10.
// ----------------------------------------------------------------------------
module tic_window_packet_receiver_core
  import twpr_pkg::*;
#(
  parameter int unsigned NODES   = 4,
  parameter int unsigned PLAYERS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [HoldoffW-1:0] cfg_wdata_i,

  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // source_node, player_id, start_low, tic_count, retransmit_low, local_tic
  input  logic [InDataW-1:0]  s_axis_tdata,
  // flag_setup, flag_exit, flag_kill, flag_retransmit
  input  logic [InUserW-1:0]  s_axis_tuser,

  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // player_out, copy_offset, copy_count, first_dest_tic, node_tic_now,
  // need_resend_now, resend_armed, resend_from, zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  // verdict
  output logic [OutUserW-1:0] m_axis_tuser
);

  localparam int unsigned NodeW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned PlW   = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;

  logic [HoldoffW-1:0]   holdoff_cfg_q;

  logic                  in_valid_q;
  in_data_t              in_data_q;
  in_user_t              in_user_q;

  logic                  out_valid_q;
  out_data_t             out_data_q, out_data_d;
  verdict_e              verdict_q, verdict_d;

  logic [TicW-1:0]       node_tic_q        [NODES];
  logic [TicW-1:0]       node_tic_d        [NODES];
  logic                  need_resend_q     [NODES];
  logic                  need_resend_d     [NODES];
  logic [TicW-1:0]       resend_from_tic_q [NODES];
  logic [TicW-1:0]       resend_from_tic_d [NODES];
  logic [HoldoffW-1:0]   holdoff_count_q   [NODES];
  logic [HoldoffW-1:0]   holdoff_count_d   [NODES];
  logic                  node_present_q    [NODES];
  logic                  node_present_d    [NODES];
  logic [NodeFieldW-1:0] node_of_player_q  [PLAYERS];
  logic [NodeFieldW-1:0] node_of_player_d  [PLAYERS];

  logic                  advance;
  logic                  node_ok;
  logic                  player_ok;
  logic [4:0]            node_ext;
  logic [NodeW-1:0]      nidx;
  logic [PlW-1:0]        pidx;
  logic [TicW-1:0]       rstart, rend, rretx, nt;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  assign node_ext  = {3'b000, in_data_q.source_node};
  assign node_ok   = node_ext < 5'(NODES);
  assign nidx      = node_ext[NodeW-1:0];
  assign player_ok = {1'b0, in_data_q.player_id} < 8'(PLAYERS);
  assign pidx      = in_data_q.player_id[PlW-1:0];

  assign rstart = expand_low(in_data_q.start_low, in_data_q.local_tic);
  assign rretx  = expand_low(in_data_q.retransmit_low, in_data_q.local_tic);
  assign rend   = rstart + {{(TicW-LowW){1'b0}}, in_data_q.tic_count};
  assign nt     = node_ok ? node_tic_q[nidx] : '0;

  always_comb begin
    node_tic_d        = node_tic_q;
    need_resend_d     = need_resend_q;
    resend_from_tic_d = resend_from_tic_q;
    holdoff_count_d   = holdoff_count_q;
    node_present_d    = node_present_q;
    node_of_player_d  = node_of_player_q;

    verdict_d  = VERDICT_SETUP;
    out_data_d = '0;
    out_data_d.player_out = in_data_q.player_id;

    if (advance && node_ok) begin
      priority if (in_user_q.flag_setup) begin
        verdict_d = VERDICT_SETUP;
      end else if (in_user_q.flag_exit) begin
        if (node_present_q[nidx]) begin
          node_present_d[nidx] = 1'b0;
          verdict_d = VERDICT_EXIT;
        end else begin
          verdict_d = VERDICT_EXIT_IGN;
        end
      end else if (in_user_q.flag_kill) begin
        verdict_d = VERDICT_KILL;
      end else begin
        if (player_ok) begin
          node_of_player_d[pidx] = in_data_q.source_node;
        end
        if (holdoff_count_q[nidx] == '0 && in_user_q.flag_retransmit) begin
          resend_from_tic_d[nidx] = rretx;
          holdoff_count_d[nidx]   = holdoff_cfg_q;
          out_data_d.resend_armed = 1'b1;
        end else if (holdoff_count_q[nidx] != '0) begin
          holdoff_count_d[nidx] = holdoff_count_q[nidx] - HoldoffW'(1);
        end

        priority if (rend == nt) begin
          verdict_d = VERDICT_DUP;
        end else if ($signed(rend) < $signed(nt)) begin
          verdict_d = VERDICT_OOO;
        end else if ($signed(rstart) > $signed(nt)) begin
          need_resend_d[nidx] = 1'b1;
          verdict_d = VERDICT_MISSED;
        end else begin
          need_resend_d[nidx]       = 1'b0;
          out_data_d.copy_offset    = LowW'(nt - rstart);
          out_data_d.copy_count     = LowW'(rend - nt);
          out_data_d.first_dest_tic = nt;
          node_tic_d[nidx]          = rend;
          verdict_d = VERDICT_ACCEPT;
        end
      end

      out_data_d.node_tic_now    = node_tic_d[nidx];
      out_data_d.need_resend_now = need_resend_d[nidx];
      out_data_d.resend_from     = resend_from_tic_d[nidx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holdoff_cfg_q <= HoldoffReset;
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      for (int i = 0; i < NODES; i++) begin
        node_tic_q[i]        <= '0;
        need_resend_q[i]     <= 1'b0;
        resend_from_tic_q[i] <= '0;
        holdoff_count_q[i]   <= '0;
        node_present_q[i]    <= 1'b1;
      end
      for (int i = 0; i < PLAYERS; i++) begin
        node_of_player_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        holdoff_cfg_q <= cfg_wdata_i;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      node_tic_q        <= node_tic_d;
      need_resend_q     <= need_resend_d;
      resend_from_tic_q <= resend_from_tic_d;
      holdoff_count_q   <= holdoff_count_d;
      node_present_q    <= node_present_d;
      node_of_player_q  <= node_of_player_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= in_data_t'(s_axis_tdata);
      in_user_q <= in_user_t'(s_axis_tuser);
    end
    if (advance) begin
      out_data_q <= out_data_d;
      verdict_q  <= verdict_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = verdict_q;

endmodule

/* hdl/twpr_checker.sv */
// ----------------------------------------------------------------------------
// twpr_checker
// Port-level checks of the tic window packet receiver result stream.
// ----------------------------------------------------------------------------
module twpr_checker
  import twpr_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [OutUserW-1:0] m_axis_tuser
);

  out_data_t od;
  verdict_e  vd;

  assign od = out_data_t'(m_axis_tdata);
  assign vd = verdict_e'(m_axis_tuser);

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_slice_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && vd != VERDICT_ACCEPT |->
      od.copy_offset == '0 && od.copy_count == '0 && od.first_dest_tic == '0)
    else $error("payload slice on a packet that was not accepted");

  a_accept_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && vd == VERDICT_ACCEPT |->
      od.node_tic_now[LowW-1:0] == LowW'(od.first_dest_tic[LowW-1:0] + od.copy_count)
      && !od.need_resend_now)
    else $error("accepted packet left inconsistent node state");

  a_missed_resend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && vd == VERDICT_MISSED |-> od.need_resend_now)
    else $error("missed packet did not request a resend");

  a_armed_judged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && od.resend_armed |->
      vd == VERDICT_DUP || vd == VERDICT_OOO || vd == VERDICT_MISSED ||
      vd == VERDICT_ACCEPT)
    else $error("resend armed on a control packet");

endmodule

bind tic_window_packet_receiver_core twpr_checker u_twpr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
